// File: sv/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants of the 3-D voxel ray traversal unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vrt_pkg;

  localparam int KEY_BITS = 24;
  localparam int MAX_RUN  = 64;

  localparam int COORD_W = 32;   // Q16.16 coordinate
  localparam int VS_W    = 25;   // voxel size register
  localparam int LIM_W   = 7;    // voxel limit register
  localparam int CFG_W   = 25;   // widest config register
  localparam int FK_W    = 33;   // full precision key
  localparam int AD_W    = 33;   // |end - start|
  localparam int T_W     = 48;   // unsigned Q16.32 ray parameter
  localparam int NUM_W   = 64;   // divider numerator
  localparam int DEN_W   = 34;   // divider denominator

  localparam logic [T_W-1:0] T_SAT = {T_W{1'b1}};

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // configuration register indexes
  localparam logic CFG_VOXEL_SIZE  = 1'b0;
  localparam logic CFG_VOXEL_LIMIT = 1'b1;

  // one ray after setup, ready to walk
  typedef struct packed {
    logic [2:0][FK_W-1:0] cur;
    logic [2:0][FK_W-1:0] tgt;
    logic [2:0]           dir_neg;
    logic [2:0]           dir_zero;
    logic [2:0][T_W-1:0]  nc;
    logic [2:0][T_W-1:0]  cs;
    logic [LIM_W-1:0]     lim;
  } walk_rec_t;

endpackage

`default_nettype wire

// File: sv/vrt_div.sv
// ----------------------------------------------------------------------------
// vrt_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [vrt_pkg::NUM_W-1:0]  num,
  input  wire logic [vrt_pkg::DEN_W-1:0]  den,
  output logic                            done,
  output logic [vrt_pkg::NUM_W-1:0]       quo,
  output logic [vrt_pkg::DEN_W-1:0]       rem
);
  import vrt_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [NUM_W-1:0]     quo_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W:0]       sh;
  logic                 ge;
  logic [DEN_W:0]       diff;

  assign sh   = {rem_r, quo_r[NUM_W-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// File: sv/vrt_front.sv
// ----------------------------------------------------------------------------
// vrt_front
// Ray setup: start and end keys, first crossing and crossing spacing per axis
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_start_x,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_start_y,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_start_z,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_end_x,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_end_y,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_end_z,
  input  wire logic [vrt_pkg::VS_W-1:0]      vs,
  input  wire logic [vrt_pkg::LIM_W-1:0]     limit,
  input  wire logic                          q_full,
  output logic                               q_push,
  output vrt_pkg::walk_rec_t                 q_rec
);
  import vrt_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_GO, F_WAIT, F_PUSH} fstate_t;

  // per axis operation order
  localparam logic [1:0] K_START = 2'd0;
  localparam logic [1:0] K_END   = 2'd1;
  localparam logic [1:0] K_NEXT  = 2'd2;
  localparam logic [1:0] K_SPACE = 2'd3;

  fstate_t                 st_r;
  logic [3:0]              op_r;
  logic signed [COORD_W-1:0] s_r [3];
  logic signed [COORD_W-1:0] e_r [3];
  logic [AD_W-1:0]         ad_r [3];
  logic [2:0]              dneg_r;
  logic [2:0]              dzero_r;
  logic [VS_W-1:0]         vs_r;
  logic [VS_W-1:0]         dist_r;
  walk_rec_t               rec_r;

  logic [1:0]              ax;
  logic [1:0]              kind;
  logic [3:0]              op_nxt;
  logic signed [COORD_W-1:0] src;
  logic [COORD_W-1:0]      src_abs;
  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quo;
  logic [DEN_W-1:0]        div_rem;
  logic [FK_W-1:0]         q_key;
  logic [FK_W-1:0]         fkey;
  logic [VS_W-1:0]         r_lo;
  logic                    rnz;
  logic [VS_W-1:0]         rem_floor;
  logic [VS_W-1:0]         dist_new;
  logic [T_W-1:0]          t_sat;
  logic signed [COORD_W:0] d_in [3];
  logic [LIM_W-1:0]        lim_cap;

  assign ax   = op_r[3:2];
  assign kind = op_r[1:0];

  assign src     = (kind == K_START) ? s_r[ax] : e_r[ax];
  assign src_abs = src[COORD_W-1] ? (~src + 1'b1) : src;

  always_comb begin
    case (kind)
      K_START, K_END: begin
        div_num = {{(NUM_W-COORD_W){1'b0}}, src_abs};
        div_den = {{(DEN_W-VS_W){1'b0}}, vs_r};
      end
      K_NEXT: begin
        div_num = {{(NUM_W-VS_W-32){1'b0}}, dist_r, 32'd0};
        div_den = {{(DEN_W-AD_W){1'b0}}, ad_r[ax]};
      end
      default: begin
        div_num = {{(NUM_W-VS_W-32){1'b0}}, vs_r, 32'd0};
        div_den = {{(DEN_W-AD_W){1'b0}}, ad_r[ax]};
      end
    endcase
  end

  assign div_start = (st_r == F_GO);

  vrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // floor division from the magnitude quotient
  assign q_key     = div_quo[FK_W-1:0];
  assign r_lo      = div_rem[VS_W-1:0];
  assign rnz       = (r_lo != '0);
  assign fkey      = src[COORD_W-1] ? (~q_key + {{(FK_W-1){1'b0}}, ~rnz}) : q_key;
  assign rem_floor = !src[COORD_W-1] ? r_lo : (rnz ? (vs_r - r_lo) : '0);
  assign dist_new  = dneg_r[ax] ? rem_floor : (vs_r - rem_floor);
  assign t_sat     = (div_quo[NUM_W-1:T_W] != '0) ? T_SAT : div_quo[T_W-1:0];

  // a parallel axis skips its two t divisions
  assign op_nxt = (kind == K_END && dzero_r[ax]) ? {ax + 2'd1, K_START} : op_r + 4'd1;

  assign d_in[0] = {in_end_x[COORD_W-1], in_end_x} - {in_start_x[COORD_W-1], in_start_x};
  assign d_in[1] = {in_end_y[COORD_W-1], in_end_y} - {in_start_y[COORD_W-1], in_start_y};
  assign d_in[2] = {in_end_z[COORD_W-1], in_end_z} - {in_start_z[COORD_W-1], in_start_z};

  assign lim_cap = (limit > LIM_W'(MAX_RUN)) ? LIM_W'(MAX_RUN) : limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      op_r <= '0;
    end else begin
      case (st_r)
        F_IDLE: begin
          if (in_valid && lim_cap != '0) begin
            st_r <= F_GO;
            op_r <= '0;
          end
        end
        F_GO: st_r <= F_WAIT;
        F_WAIT: begin
          if (div_done) begin
            op_r <= op_nxt;
            st_r <= (op_nxt[3:2] == 2'd3) ? F_PUSH : F_GO;
          end
        end
        F_PUSH: begin
          if (!q_full) st_r <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_valid) begin
      s_r[0] <= in_start_x;
      s_r[1] <= in_start_y;
      s_r[2] <= in_start_z;
      e_r[0] <= in_end_x;
      e_r[1] <= in_end_y;
      e_r[2] <= in_end_z;
      for (int i = 0; i < 3; i++) begin
        dneg_r[i]     <= d_in[i][COORD_W];
        dzero_r[i]    <= (d_in[i] == '0);
        ad_r[i]       <= d_in[i][COORD_W] ? AD_W'(-d_in[i]) : AD_W'(d_in[i]);
        rec_r.nc[i]   <= T_SAT;
        rec_r.cs[i]   <= T_SAT;
        rec_r.dir_neg[i]  <= d_in[i][COORD_W];
        rec_r.dir_zero[i] <= (d_in[i] == '0);
      end
      vs_r      <= (vs == '0) ? VS_W'(1) : vs;
      rec_r.lim <= lim_cap;
    end else if (st_r == F_WAIT && div_done) begin
      case (kind)
        K_START: begin
          rec_r.cur[ax] <= fkey;
          dist_r        <= dist_new;
        end
        K_END:   rec_r.tgt[ax] <= fkey;
        K_NEXT:  rec_r.nc[ax]  <= t_sat;
        default: rec_r.cs[ax]  <= t_sat;
      endcase
    end
  end

  assign in_stall = (st_r != F_IDLE);
  assign q_push   = (st_r == F_PUSH) && !q_full;
  assign q_rec    = rec_r;

endmodule

`default_nettype wire

// File: sv/vrt_fifo.sv
// ----------------------------------------------------------------------------
// vrt_fifo
// Short queue of set-up rays between setup and walker
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire vrt_pkg::walk_rec_t wdata,
  input  wire logic               pop,
  output vrt_pkg::walk_rec_t      rdata,
  output logic                    full,
  output logic                    empty
);
  import vrt_pkg::*;

  walk_rec_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r;
  logic [Q_AW-1:0]   rp_r;
  logic [Q_AW:0]     cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  assign rdata = mem_r[rp_r];
  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// File: sv/vrt_walk.sv
// ----------------------------------------------------------------------------
// vrt_walk
// DDA walker: one voxel key per cycle, while out_stall allows, into an output register
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_walk (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire vrt_pkg::walk_rec_t  q_rec,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [vrt_pkg::KEY_BITS-1:0] out_key_x,
  output logic signed [vrt_pkg::KEY_BITS-1:0] out_key_y,
  output logic signed [vrt_pkg::KEY_BITS-1:0] out_key_z,
  output logic                     out_last
);
  import vrt_pkg::*;

  typedef enum logic {W_IDLE, W_RUN} wstate_t;

  wstate_t          st_r;
  logic [FK_W-1:0]  cur_r [3];
  logic [FK_W-1:0]  tgt_r [3];
  logic [2:0]       neg_r;
  logic [2:0]       zero_r;
  logic [T_W-1:0]   nc_r [3];
  logic [T_W-1:0]   cs_r [3];
  logic [LIM_W-1:0] lim_r;
  logic [LIM_W-1:0] n_r;
  logic             out_valid_r;
  logic [KEY_BITS-1:0] kx_r, ky_r, kz_r;
  logic             last_r;

  logic             out_free;
  logic             emit;
  logic             at_end;
  logic [LIM_W:0]   n_inc;
  logic [1:0]       m;
  logic [1:0]       m01;
  logic [T_W:0]     t_sum;
  logic [T_W-1:0]   t_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (st_r == W_RUN) && out_free;
  assign n_inc    = {1'b0, n_r} + 1'b1;
  assign at_end   = (n_inc >= {1'b0, lim_r}) ||
                    (cur_r[0] == tgt_r[0] && cur_r[1] == tgt_r[1] && cur_r[2] == tgt_r[2]);

  // lowest axis wins ties
  assign m01   = (nc_r[1] < nc_r[0]) ? 2'd1 : 2'd0;
  assign m     = (nc_r[2] < nc_r[m01]) ? 2'd2 : m01;
  assign t_sum = {1'b0, nc_r[m]} + {1'b0, cs_r[m]};
  assign t_nxt = t_sum[T_W] ? T_SAT : t_sum[T_W-1:0];

  assign q_pop = (st_r == W_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= W_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (st_r)
        W_IDLE: begin
          if (!q_empty) begin
            st_r <= W_RUN;
            n_r  <= '0;
          end
        end
        W_RUN: begin
          if (emit) begin
            n_r <= n_inc[LIM_W-1:0];
            if (at_end) st_r <= W_IDLE;
          end
        end
        default: st_r <= W_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 3; i++) begin
        cur_r[i] <= q_rec.cur[i];
        tgt_r[i] <= q_rec.tgt[i];
        nc_r[i]  <= q_rec.nc[i];
        cs_r[i]  <= q_rec.cs[i];
      end
      neg_r  <= q_rec.dir_neg;
      zero_r <= q_rec.dir_zero;
      lim_r  <= q_rec.lim;
    end else if (emit) begin
      kx_r   <= cur_r[0][KEY_BITS-1:0];
      ky_r   <= cur_r[1][KEY_BITS-1:0];
      kz_r   <= cur_r[2][KEY_BITS-1:0];
      last_r <= at_end;
      if (!at_end) begin
        if (!zero_r[m]) begin
          cur_r[m] <= neg_r[m] ? cur_r[m] - 1'b1 : cur_r[m] + 1'b1;
        end
        nc_r[m] <= t_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_key_x = kx_r;
  assign out_key_y = ky_r;
  assign out_key_z = kz_r;
  assign out_last  = last_r;

  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == W_RUN) |-> (n_r < lim_r))
    else $error("walker ran past its voxel limit");
  a_last_ends_ray: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && at_end) |=> (st_r == W_IDLE))
    else $error("walker kept running after the final key");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == W_IDLE))
    else $error("ray taken while walking");

endmodule

`default_nettype wire

// File: sv/voxel_ray_traversal_3d_unit.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_3d_unit
// 3-D voxel ray traversal: emits the voxel keys a ray segment passes through
// ----------------------------------------------------------------------------
// One ray in, one to voxel_limit (capped at 64) keys out, the final key flagged by out_last.
// Setup runs on a single shared divider that makes one quotient bit per
// cycle; a ray needs 6 divisions plus 2 more per non-parallel axis. The
// walker then emits one key per cycle while out_stall is low, up to 64
// keys. A two-entry queue between setup and walker lets the next ray be
// set up while the current one walks. A voxel_limit of zero drops the
// ray without any output.
`default_nettype none

module voxel_ray_traversal_3d_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_start_x,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_start_y,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_start_z,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_end_x,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_end_y,
  input  wire logic signed [vrt_pkg::COORD_W-1:0] in_end_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [vrt_pkg::KEY_BITS-1:0]     out_key_x,
  output logic signed [vrt_pkg::KEY_BITS-1:0]     out_key_y,
  output logic signed [vrt_pkg::KEY_BITS-1:0]     out_key_z,
  output logic                                    out_last,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [vrt_pkg::CFG_W-1:0]          cfg_data
);
  import vrt_pkg::*;

  logic [VS_W-1:0]  vs_r;
  logic [LIM_W-1:0] lim_r;

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  walk_rec_t q_wrec;
  walk_rec_t q_rrec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r  <= VS_W'(13107);
      lim_r <= LIM_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VOXEL_SIZE:  vs_r  <= cfg_data[VS_W-1:0];
        CFG_VOXEL_LIMIT: lim_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  vrt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_start_z (in_start_z),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .in_end_z   (in_end_z),
    .vs         (vs_r),
    .limit      (lim_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_rec      (q_wrec)
  );

  vrt_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wrec),
    .pop   (q_pop),
    .rdata (q_rrec),
    .full  (q_full),
    .empty (q_empty)
  );

  vrt_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (q_rrec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_key_x (out_key_x),
    .out_key_y (out_key_y),
    .out_key_z (out_key_z),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3-D voxel ray traversal unit.
// ----------------------------------------------------------------------------
// Rays go in through a queue-fed driver. Each accepted ray is walked by an
// in-bench DDA model and its voxel keys are queued. A monitor compares every
// key word with the oldest queued key. Voxel size and limit are changed
// between phases while the unit is idle.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vrt_pkg::*;

  localparam logic [47:0] TSAT = {48{1'b1}};

  typedef struct {
    logic signed [31:0] s[3];
    logic signed [31:0] e[3];
  } ray_t;

  typedef struct {
    logic [KEY_BITS-1:0] k[3];
    logic                lst;
  } key_word_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_last;
  logic signed [31:0] in_start_x, in_start_y, in_start_z;
  logic signed [31:0] in_end_x, in_end_y, in_end_z;
  logic signed [KEY_BITS-1:0] out_key_x, out_key_y, out_key_z;
  logic cfg_we, cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ray_t      pending_rays[$];
  key_word_t expected_keys[$];
  logic [24:0] vox_size;
  logic [6:0]  vox_limit;
  int send_idle_pct, recv_idle_pct;
  int mismatches;
  bit timed_out;

  voxel_ray_traversal_3d_unit uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_by(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic [47:0] t_quot(longint num, longint den);
    logic [95:0] q;
    q = ({32'd0, 64'(num)} << 32) / 96'(den);
    return q > 96'(TSAT) ? TSAT : q[47:0];
  endfunction

  // walk one ray through the grid and queue its keys
  task automatic walk_ray(ray_t r);
    longint vs, sp, ep, d, gap, cur[3], tgt[3];
    logic [48:0] nc[3], cs[3];
    int stp[3];
    int lim, n, m;
    bit same;
    key_word_t w;
    vs = (vox_size == 0) ? 1 : longint'(vox_size);
    lim = (vox_limit > MAX_RUN) ? MAX_RUN : vox_limit;
    same = 1;
    for (int a = 0; a < 3; a++) begin
      sp = r.s[a];
      ep = r.e[a];
      if (sp != ep) same = 0;
      cur[a] = floor_by(sp, vs);
      tgt[a] = floor_by(ep, vs);
      d = ep - sp;
      if (d == 0) begin
        stp[a] = 0;
        nc[a] = TSAT;
        cs[a] = TSAT;
      end else begin
        if (d > 0) begin
          stp[a] = 1;
          gap = (cur[a] + 1) * vs - sp;
        end else begin
          stp[a] = -1;
          gap = sp - cur[a] * vs;
          d = -d;
        end
        if (gap < 0) gap = 0;
        nc[a] = t_quot(gap, d);
        cs[a] = t_quot(vs, d);
      end
    end
    if (lim == 0) return;
    n = 0;
    while (1) begin
      for (int a = 0; a < 3; a++) w.k[a] = cur[a][KEY_BITS-1:0];
      n++;
      w.lst = same || n >= lim || (cur[0] == tgt[0] && cur[1] == tgt[1] && cur[2] == tgt[2]);
      expected_keys = {expected_keys, w};
      if (w.lst) break;
      m = 0;
      if (nc[1] < nc[0]) m = 1;
      if (nc[2] < nc[m]) m = 2;
      cur[m] += stp[m];
      nc[m] = nc[m] + cs[m];
      if (nc[m] > TSAT) nc[m] = TSAT;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) walk_ray('{s: '{in_start_x, in_start_y, in_start_z},
                                e: '{in_end_x, in_end_y, in_end_z}});
      if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        ray_t r;
        r = pending_rays.pop_front();
        in_valid   <= 1;
        in_start_x <= r.s[0]; in_start_y <= r.s[1]; in_start_z <= r.s[2];
        in_end_x   <= r.e[0]; in_end_y   <= r.e[1]; in_end_z   <= r.e[2];
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_keys.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected key word %0d %0d %0d",
                                         out_key_x, out_key_y, out_key_z);
        end else begin
          key_word_t w;
          w = expected_keys.pop_front();
          if (w.k[0] !== out_key_x || w.k[1] !== out_key_y || w.k[2] !== out_key_z ||
              w.lst !== out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("key mismatch: exp %h %h %h last %b, got %h %h %h last %b",
                       w.k[0], w.k[1], w.k[2], w.lst,
                       out_key_x, out_key_y, out_key_z, out_last);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == CFG_VOXEL_SIZE) vox_size = val[24:0];
    else vox_limit = val[6:0];
  endtask

  task automatic wait_drained();
    while (pending_rays.size() > 0 || in_valid || expected_keys.size() > 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      default: return 32'($signed($urandom_range(0, 400 * 65536)) - 200 * 65536);
    endcase
  endfunction

  task automatic add_ray(logic [31:0] sx, sy, sz, ex, ey, ez);
    ray_t r;
    r.s = '{sx, sy, sz};
    r.e = '{ex, ey, ez};
    pending_rays = {pending_rays, r};
  endtask

  task automatic add_random(int cnt);
    int mode;
    logic [31:0] c[6];
    for (int i = 0; i < cnt; i++) begin
      mode = $urandom_range(9) < 6 ? 1 : ($urandom_range(1) ? 0 : 2);
      foreach (c[j]) c[j] = rand_coord(mode);
      // parallel axes and boundary starts now and then
      if ($urandom_range(4) == 0) c[3 + $urandom_range(2)] = c[0];
      if ($urandom_range(5) == 0) c[1] = {16'($urandom_range(0, 7) - 4), 16'd0};
      if ($urandom_range(30) == 0) for (int j = 0; j < 3; j++) c[3 + j] = c[j];
      add_ray(c[0], c[1], c[2], c[3], c[4], c[5]);
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; out_stall = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_start_x = 0; in_start_y = 0; in_start_z = 0;
    in_end_x = 0; in_end_y = 0; in_end_z = 0;
    vox_size = 13107; vox_limit = 64;
    mismatches = 0;
    send_idle_pct = 31; recv_idle_pct = 71;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed rays at reset settings
    add_ray(0, 0, 0, 0, 0, 0);
    add_ray(32'h0001_8000, 32'hfffe_0000, 0, 32'h0001_8000, 32'hfffe_0000, 0);
    add_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    add_ray(32'h0000_3333, 0, 0, 32'hffff_0000, 0, 0);
    add_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_ray(32'hffff_ffff, 0, 1, 1, 32'hffff_ffff, 32'hffff_ffff);
    add_ray(0, 0, 0, 1, 0, 0);
    add_ray(0, 0, 0, 0, 32'h0000_2000, 32'h0000_2000);
    add_random(80);
    wait_drained();

    write_reg(CFG_VOXEL_SIZE, 256);
    write_reg(CFG_VOXEL_LIMIT, 1);
    add_ray(0, 0, 0, 32'h0000_1000, 0, 0);
    add_ray(5, 5, 5, 5, 5, 5);
    add_random(10);
    wait_drained();

    write_reg(CFG_VOXEL_LIMIT, 0);
    add_ray(0, 0, 0, 32'h0000_1000, 0, 0);
    add_ray(7, 7, 7, 7, 7, 7);
    add_random(6);
    wait_drained();

    send_idle_pct = 71; recv_idle_pct = 31;
    write_reg(CFG_VOXEL_SIZE, 25'h1ff_ffff);
    write_reg(CFG_VOXEL_LIMIT, 7'h7f);
    add_random(30);
    wait_drained();
    write_reg(CFG_VOXEL_SIZE, 0);
    add_ray(0, 0, 0, 32'h0000_0100, 32'h0000_0080, 0);
    add_random(10);
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(CFG_VOXEL_SIZE, 16777216);
    write_reg(CFG_VOXEL_LIMIT, 64);
    add_random(30);
    wait_drained();
    write_reg(CFG_VOXEL_SIZE, 65536);
    write_reg(CFG_VOXEL_LIMIT, 17);
    add_random(30);
    wait_drained();

    if (mismatches == 0 && expected_keys.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

`default_nettype wire
